FILE: rtl/eilf_pkg.sv
// Shared constants, coefficient table and controller/datapath command types
// for the elliptic IIR low-pass filter. No dependencies.
package eilf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;              // Q6.18
    localparam int COEF_FRAC  = 18;
    localparam int ORDER      = 7;
    localparam int NUM_TAPS   = 2 * ORDER + 1;   // b0..b7, then -a1..-a7
    localparam int STEP_W     = $clog2(NUM_TAPS);
    localparam int TAB_LEN    = 2 ** STEP_W;
    localparam int HIST_IDX_W = $clog2(ORDER);
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 48;
    localparam int NUM_SETS   = 2;
    localparam int COEF_SCALE = 10000;           // table entries are in units of 1e-4

    // Decimal coefficient (units of 1e-4) to Q6.18, ties away from zero.
    // Only evaluated at elaboration.
    function automatic logic signed [COEF_W-1:0] to_fixed(longint c4);
        longint scaled;
        scaled = c4 * (longint'(1) << COEF_FRAC);
        if (scaled >= 0) begin
            scaled = (scaled + COEF_SCALE / 2) / COEF_SCALE;
        end else begin
            scaled = (scaled - COEF_SCALE / 2) / COEF_SCALE;
        end
        return scaled[COEF_W-1:0];
    endfunction

    // Per set, indexed by MAC step: b0..b7 then the negated feedback taps a1..a7.
    localparam logic signed [COEF_W-1:0] COEF_TAB [NUM_SETS][TAB_LEN] = '{
        '{to_fixed(524), to_fixed(-2680), to_fixed(6099), to_fixed(-7881),
          to_fixed(6099), to_fixed(-2680), to_fixed(524), to_fixed(0),
          to_fixed(53037), to_fixed(-119131), to_fixed(144834), to_fixed(-100426),
          to_fixed(37634), to_fixed(-5954), to_fixed(0), to_fixed(0)},
        '{to_fixed(856), to_fixed(-1237), to_fixed(2072), to_fixed(-381),
          to_fixed(-381), to_fixed(2072), to_fixed(-1237), to_fixed(856),
          to_fixed(34902), to_fixed(-68197), to_fixed(82474), to_fixed(-68023),
          to_fixed(36701), to_fixed(-12386), to_fixed(1908), to_fixed(0)}
    };

    typedef struct packed {
        logic              load_x;   // latch new sample, clear accumulator
        logic              mul;      // multiply tap at step
        logic [STEP_W-1:0] step;
        logic              finish;   // round, load output, shift delay lines
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;              // output register can take a result
    } t_dp_status;

endpackage

FILE: rtl/eilf_in_if.sv
// Input sample channel: valid/ready request with one Q1.15 sample.
// Depends on eilf_pkg.
interface eilf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [eilf_pkg::SAMPLE_W-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: rtl/eilf_out_if.sv
// Output result channel: valid/ready request with filtered sample and clip flag.
// Depends on eilf_pkg.
interface eilf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [eilf_pkg::SAMPLE_W-1:0]  sample_out;
    logic                                  clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: rtl/eilf_ctrl.sv
// Sequencer for the filter: steps the shared multiplier through all taps.
// Depends on eilf_pkg.
module eilf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  eilf_pkg::t_dp_status i_status,
    output eilf_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_FLUSH,
        S_DONE
    } t_state;

    localparam logic [eilf_pkg::STEP_W-1:0] LAST_STEP =
        eilf_pkg::STEP_W'(eilf_pkg::NUM_TAPS - 1);

    t_state                        r_state;
    logic [eilf_pkg::STEP_W-1:0]   r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MAC;
                        r_step  <= '0;
                    end
                end
                S_MAC: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_step <= r_step + eilf_pkg::STEP_W'(1);
                    end
                end
                // last product lands in the accumulator
                S_FLUSH: r_state <= S_DONE;
                S_DONE: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.load_x  = o_in_ready && i_in_valid;
    assign o_cmd.mul     = (r_state == S_MAC);
    assign o_cmd.step    = r_step;
    assign o_cmd.finish  = (r_state == S_DONE) && i_status.out_free;

`ifndef SYNTHESIS
    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_x |=> (r_state == S_MAC && r_step == '0))
        else $error("accepted request did not start the MAC sweep at step 0");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_step <= LAST_STEP))
        else $error("MAC step beyond last tap");

    a_full_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> ($past(r_state) == S_MAC && $past(r_step) == LAST_STEP))
        else $error("flush entered before all taps were multiplied");
`endif

endmodule

FILE: rtl/eilf_dp.sv
// Datapath: delay lines, coefficient select, shared multiplier, accumulator,
// round/saturate and output register. Depends on eilf_pkg.
module eilf_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_wdata,
    input  logic signed [eilf_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  eilf_pkg::t_dp_cmd                     i_cmd,
    output eilf_pkg::t_dp_status                  o_status,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [eilf_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_clipped
);

    localparam int SHIFT_W = eilf_pkg::ACC_W - eilf_pkg::COEF_FRAC;
    localparam int SW      = eilf_pkg::SAMPLE_W;

    logic                                 r_set;
    logic signed [SW-1:0]                 r_x;
    logic signed [SW-1:0]                 r_xh [eilf_pkg::ORDER];
    logic signed [SW-1:0]                 r_yh [eilf_pkg::ORDER];
    logic signed [eilf_pkg::PROD_W-1:0]   r_prod;
    logic                                 r_prod_vld;
    logic signed [eilf_pkg::ACC_W-1:0]    r_acc;
    logic                                 r_out_vld;
    logic signed [SW-1:0]                 r_out;
    logic                                 r_clip;

    logic [eilf_pkg::STEP_W-1:0]          w_xs;
    logic [eilf_pkg::STEP_W-1:0]          w_ys;
    logic signed [SW-1:0]                 w_opnd;
    logic signed [eilf_pkg::COEF_W-1:0]   w_coef;
    logic signed [eilf_pkg::ACC_W-1:0]    w_rnd;
    logic [SHIFT_W-1:0]                   w_shift;
    logic [SHIFT_W-SW:0]                  w_top;
    logic                                 w_ovf;
    logic signed [SW-1:0]                 w_y;

    // steps 0..ORDER walk the input line (step 0 is the new sample),
    // the remaining steps walk the output line
    assign w_xs = i_cmd.step - eilf_pkg::STEP_W'(1);
    assign w_ys = i_cmd.step - eilf_pkg::STEP_W'(eilf_pkg::ORDER + 1);

    always_comb begin
        if (i_cmd.step == '0) begin
            w_opnd = r_x;
        end else if (i_cmd.step <= eilf_pkg::STEP_W'(eilf_pkg::ORDER)) begin
            w_opnd = r_xh[w_xs[eilf_pkg::HIST_IDX_W-1:0]];
        end else begin
            w_opnd = r_yh[w_ys[eilf_pkg::HIST_IDX_W-1:0]];
        end
    end

    assign w_coef = eilf_pkg::COEF_TAB[r_set][i_cmd.step];

    // round half up, then arithmetic shift to Q1.15
    assign w_rnd   = r_acc + (eilf_pkg::ACC_W'(1) << (eilf_pkg::COEF_FRAC - 1));
    assign w_shift = w_rnd[eilf_pkg::ACC_W-1:eilf_pkg::COEF_FRAC];
    assign w_top   = w_shift[SHIFT_W-1:SW-1];
    assign w_ovf   = !((&w_top) || !(|w_top));

    always_comb begin
        if (!w_ovf) begin
            w_y = signed'(w_shift[SW-1:0]);
        end else if (w_shift[SHIFT_W-1]) begin
            w_y = {1'b1, {(SW-1){1'b0}}};
        end else begin
            w_y = {1'b0, {(SW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set      <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < eilf_pkg::ORDER; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
        end else begin
            r_prod_vld <= i_cmd.mul;
            if (i_cfg_we) begin
                r_set <= i_cfg_wdata;
                for (int i = 0; i < eilf_pkg::ORDER; i++) begin
                    r_xh[i] <= '0;
                    r_yh[i] <= '0;
                end
            end else if (i_cmd.finish) begin
                for (int i = eilf_pkg::ORDER - 1; i > 0; i--) begin
                    r_xh[i] <= r_xh[i-1];
                    r_yh[i] <= r_yh[i-1];
                end
                r_xh[0] <= r_x;
                r_yh[0] <= w_y;
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul) begin
            r_prod <= w_coef * w_opnd;
        end
        if (i_cmd.load_x) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{(eilf_pkg::ACC_W - eilf_pkg::PROD_W){r_prod[eilf_pkg::PROD_W-1]}},
                              r_prod};
        end
        if (i_cmd.finish) begin
            r_out  <= w_y;
            r_clip <= w_ovf;
        end
    end

    assign o_status.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid       = r_out_vld;
    assign o_sample_out      = r_out;
    assign o_clipped         = r_clip;

endmodule

FILE: rtl/elliptic_iir_lowpass_filter.sv
// Direct form I IIR low-pass filter, signed Q1.15 in and out. Each sample is
// latched on request, then a single shared 24x16 multiplier works through
// b0..b7 and a1..a7, the last product reaches the 48-bit accumulator and,
// once the output register is free, the sum is rounded, saturated and loaded
// into the output register. The next request
// is taken once the previous result sits in the output register, even if it
// has not been taken yet. Writing i_cfg_wdata with i_cfg_we selects the
// coefficient set (0 sixth-order elliptic, 1 seventh-order) and clears both
// delay lines; write it only while no request is in progress.
// Depends on eilf_pkg, eilf_in_if, eilf_out_if, eilf_ctrl and eilf_dp.
module elliptic_iir_lowpass_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    eilf_in_if.sink     i_sample,
    eilf_out_if.source  o_result
);

    eilf_pkg::t_dp_cmd     w_cmd;
    eilf_pkg::t_dp_status  w_status;
    logic                  w_in_ready;

    eilf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    eilf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample_in  (i_sample.sample_in),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (o_result.valid),
        .i_out_ready  (o_result.ready),
        .o_sample_out (o_result.sample_out),
        .o_clipped    (o_result.clipped)
    );

    assign i_sample.ready = w_in_ready;

endmodule
